### hw/rtl/pmu_pkg.sv
// ----------------------------------------------------------------------------
// pmu_pkg
// Types, micro-program and defaults for the polynomial multiply unit.
// ----------------------------------------------------------------------------
package pmu_pkg;

  localparam int unsigned MaxTerms  = 16;
  localparam int unsigned CoeffW    = 32;
  localparam int unsigned PowerW    = 5;
  localparam int unsigned UpcW      = 4;
  localparam int unsigned OutDataW  = 40;

  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UpcIdle   = 4'd0;
  localparam upc_t UpcInit   = 4'd1;
  localparam upc_t UpcKStart = 4'd2;
  localparam upc_t UpcMac    = 4'd3;
  localparam upc_t UpcDrain1 = 4'd4;
  localparam upc_t UpcDrain2 = 4'd5;
  localparam upc_t UpcEmit   = 4'd6;
  localparam upc_t UpcNext   = 4'd7;
  localparam upc_t UpcDone   = 4'd8;
  localparam upc_t UpcEmpty  = 4'd9;
  localparam upc_t UpcClear  = 4'd10;

  typedef enum logic [2:0] {
    CondNext,
    CondAlways,
    CondNotBLast,
    CondAEmpty,
    CondIMore,
    CondOutBusy,
    CondKMore
  } cond_e;

  typedef struct packed {
    logic in_ready;
    logic clr_k;
    logic clr_acc;
    logic issue;
    logic emit;
    logic emit_zero;
    logic inc_k;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic b_last;
    logic a_empty;
    logic i_end;
    logic k_last;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    cond_e cond;
    upc_t  target;
    ctrl_t ctrl;
  } uword_t;

  function automatic uword_t ucode(input upc_t upc);
    uword_t w;
    w = '{cond: CondAlways, target: UpcIdle, ctrl: '0};
    case (upc)
      UpcIdle: begin
        w.cond = CondNotBLast;
        w.target = UpcIdle;
        w.ctrl.in_ready = 1'b1;
      end
      UpcInit: begin
        w.cond = CondAEmpty;
        w.target = UpcEmpty;
        w.ctrl.clr_k = 1'b1;
      end
      UpcKStart: begin
        w.cond = CondNext;
        w.ctrl.clr_acc = 1'b1;
      end
      UpcMac: begin
        w.cond = CondIMore;
        w.target = UpcMac;
        w.ctrl.issue = 1'b1;
      end
      UpcDrain1: w.cond = CondNext;
      UpcDrain2: w.cond = CondNext;
      UpcEmit: begin
        w.cond = CondOutBusy;
        w.target = UpcEmit;
        w.ctrl.emit = 1'b1;
      end
      UpcNext: begin
        w.cond = CondKMore;
        w.target = UpcKStart;
        w.ctrl.inc_k = 1'b1;
      end
      // skip over the empty-product step
      UpcDone: begin
        w.cond = CondAlways;
        w.target = UpcClear;
      end
      UpcEmpty: begin
        w.cond = CondOutBusy;
        w.target = UpcEmpty;
        w.ctrl.emit = 1'b1;
        w.ctrl.emit_zero = 1'b1;
      end
      UpcClear: begin
        w.cond = CondAlways;
        w.target = UpcIdle;
        w.ctrl.clear = 1'b1;
      end
      default: begin
        w.cond = CondAlways;
        w.target = UpcIdle;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/polynomial_multiply_unit.sv
// ----------------------------------------------------------------------------
// polynomial_multiply_unit
// Microcoded polynomial product: loads A and B terms, emits A*B coefficients.
// ----------------------------------------------------------------------------
// Loading: one term per cycle while idle. After the last B term the burst
// yields n = count_a + count_b - 1 coefficients, each built by one
// multiply-accumulate per cycle on the single store ports.
// Output waits stall the sequencer; a held result still frees the datapath.
// Reset clears the term counts, overflow mark, sequencer and output valid; store
// contents are left undefined and need no clearing pass.
module polynomial_multiply_unit #(
  parameter int unsigned MAX_TERMS = pmu_pkg::MaxTerms
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pmu_pkg::CoeffW-1:0]       s_axis_tdata,  // coeff_value
  input  logic                             s_axis_tuser,  // operand_sel
  input  logic                             s_axis_tlast,  // last_term
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pmu_pkg::OutDataW-1:0]     m_axis_tdata,  // product_coeff, power_index, pad
  output logic                             m_axis_tuser,  // overflow_flag
  output logic                             m_axis_tlast   // last_out
);

  pmu_pkg::ctrl_t ctrl;
  pmu_pkg::stat_t stat;
  logic [pmu_pkg::CoeffW-1:0] coeff;
  logic [pmu_pkg::PowerW-1:0] power;

  pmu_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pmu_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid),
    .in_sel_i    (s_axis_tuser),
    .in_coeff_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_coeff_o (coeff),
    .out_power_o (power),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tdata  = {{(pmu_pkg::OutDataW - pmu_pkg::CoeffW - pmu_pkg::PowerW){1'b0}},
                          power, coeff};

  a_busy_after_b_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast |=> !s_axis_tready)
    else $error("input still accepted after last B term");

  a_clear_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> s_axis_tready && stat.a_empty)
    else $error("stores not cleared or sequencer not idle after burst");

  a_no_load_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.issue |-> !s_axis_tready && !ctrl.emit)
    else $error("multiply step overlaps load or emit");

endmodule

### hw/rtl/pmu_ram.sv
// ----------------------------------------------------------------------------
// pmu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pmu_sequencer.sv
// ----------------------------------------------------------------------------
// pmu_sequencer
// Micro-program counter and control store; conditional jumps on status.
// ----------------------------------------------------------------------------
module pmu_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pmu_pkg::stat_t  stat_i,
  output pmu_pkg::ctrl_t  ctrl_o
);

  pmu_pkg::upc_t   upc_d, upc_q;
  pmu_pkg::uword_t uword;
  logic            take;

  always_comb begin
    uword = pmu_pkg::ucode(upc_q);
    case (uword.cond)
      pmu_pkg::CondNext:     take = 1'b0;
      pmu_pkg::CondAlways:   take = 1'b1;
      pmu_pkg::CondNotBLast: take = !stat_i.b_last;
      pmu_pkg::CondAEmpty:   take = stat_i.a_empty;
      pmu_pkg::CondIMore:    take = !stat_i.i_end;
      pmu_pkg::CondOutBusy:  take = stat_i.out_busy;
      pmu_pkg::CondKMore:    take = !stat_i.k_last;
      default:               take = 1'b1;
    endcase
    upc_d  = take ? uword.target : upc_q + pmu_pkg::upc_t'(1);
    ctrl_o = uword.ctrl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= pmu_pkg::UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

### hw/rtl/pmu_datapath.sv
// ----------------------------------------------------------------------------
// pmu_datapath
// Coefficient stores, term counters, multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module pmu_datapath #(
  parameter int unsigned MAX_TERMS = pmu_pkg::MaxTerms
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pmu_pkg::ctrl_t              ctrl_i,
  output pmu_pkg::stat_t              stat_o,
  input  logic                        in_valid_i,
  input  logic                        in_sel_i,
  input  logic [pmu_pkg::CoeffW-1:0]  in_coeff_i,
  input  logic                        in_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pmu_pkg::CoeffW-1:0]  out_coeff_o,
  output logic [pmu_pkg::PowerW-1:0]  out_power_o,
  output logic                        out_last_o,
  output logic                        out_ovf_o
);

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned KW = $clog2(2 * MAX_TERMS);

  logic [CW-1:0] ca_d, ca_q, cb_d, cb_q;
  logic          ovf_d, ovf_q;
  logic [AW-1:0] i_d, i_q;
  logic [KW-1:0] k_d, k_q;
  logic          v1_q, v2_q;
  logic [pmu_pkg::CoeffW-1:0] prod_q, acc_d, acc_q;
  logic [pmu_pkg::CoeffW-1:0] a_rd, b_rd;

  logic [KW:0]   diff;
  logic          term_ok;
  logic          accept, a_full, b_full, we_a, we_b;
  logic          out_busy, emit_fire;

  logic                        oval_q;
  logic [pmu_pkg::CoeffW-1:0]  ocoeff_q;
  logic [pmu_pkg::PowerW-1:0]  opower_q;
  logic                        olast_q, oovf_q;

  assign accept = ctrl_i.in_ready && in_valid_i;
  assign a_full = (ca_q >= CW'(MAX_TERMS));
  assign b_full = (cb_q >= CW'(MAX_TERMS));
  assign we_a   = accept && !in_sel_i && !a_full;
  assign we_b   = accept && in_sel_i && !b_full;

  assign diff    = {1'b0, k_q} - (KW+1)'(i_q);
  assign term_ok = !diff[KW] && (diff[KW-1:0] < KW'(cb_q));

  assign out_busy  = oval_q && !out_ready_i;
  assign emit_fire = ctrl_i.emit && !out_busy;

  pmu_ram #(.Width(pmu_pkg::CoeffW), .Depth(MAX_TERMS)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (ca_q[AW-1:0]),
    .wdata_i (in_coeff_i),
    .raddr_i (i_q),
    .rdata_o (a_rd)
  );

  pmu_ram #(.Width(pmu_pkg::CoeffW), .Depth(MAX_TERMS)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cb_q[AW-1:0]),
    .wdata_i (in_coeff_i),
    .raddr_i (diff[AW-1:0]),
    .rdata_o (b_rd)
  );

  always_comb begin
    ca_d  = ca_q;
    cb_d  = cb_q;
    ovf_d = ovf_q;
    if (we_a) ca_d = ca_q + CW'(1);
    if (we_b) cb_d = cb_q + CW'(1);
    if (accept && ((in_sel_i && b_full) || (!in_sel_i && a_full))) ovf_d = 1'b1;
    if (ctrl_i.clear) begin
      ca_d  = '0;
      cb_d  = '0;
      ovf_d = 1'b0;
    end
    i_d = i_q;
    if (ctrl_i.clr_acc) i_d = '0;
    else if (ctrl_i.issue) i_d = i_q + AW'(1);
    k_d = k_q;
    if (ctrl_i.clr_k) k_d = '0;
    else if (ctrl_i.inc_k) k_d = k_q + KW'(1);
    acc_d = acc_q;
    if (ctrl_i.clr_acc) acc_d = '0;
    else if (v2_q) acc_d = acc_q + prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q   <= '0;
      cb_q   <= '0;
      ovf_q  <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      ca_q  <= ca_d;
      cb_q  <= cb_d;
      ovf_q <= ovf_d;
      v1_q  <= ctrl_i.issue && term_ok;
      v2_q  <= v1_q;
      if (emit_fire) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    prod_q <= a_rd * b_rd;
    if (emit_fire) begin
      ocoeff_q <= ctrl_i.emit_zero ? '0 : acc_q;
      opower_q <= ctrl_i.emit_zero ? '0 : pmu_pkg::PowerW'(k_q);
      olast_q  <= ctrl_i.emit_zero || stat_o.k_last;
      oovf_q   <= ovf_q;
    end
  end

  assign stat_o.b_last   = accept && in_sel_i && in_last_i;
  assign stat_o.a_empty  = (ca_q == '0);
  assign stat_o.i_end    = (CW'(i_q) == ca_q - CW'(1));
  assign stat_o.k_last   = ((KW+1)'(k_q) == (KW+1)'(ca_q) + (KW+1)'(cb_q) - (KW+1)'(2));
  assign stat_o.out_busy = out_busy;

  assign out_valid_o = oval_q;
  assign out_coeff_o = ocoeff_q;
  assign out_power_o = opower_q;
  assign out_last_o  = olast_q;
  assign out_ovf_o   = oovf_q;

endmodule
